>>> sv/mssq_pkg.sv
// Shared constants and types of the medium size search sequencer.
package mssq_pkg;

   localparam int MAX_BLOCKS_LOG2_DEF = 24;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 25;
   localparam int SIZE_W   = 31;
   localparam int ERR_W    = 3;
   localparam int KIB_W    = 7;
   localparam int PHASE_W  = 3;

   localparam logic [KIB_W-1:0] KIB_RESET = 7'd2;

   // Operation codes of an input transfer.
   localparam logic OP_START    = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   // Completion status codes.
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_OPER = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INTR     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BUILD    = 3'd5;

   // Commands issued on the result channel.
   localparam logic [CMD_W-1:0] CMD_SEEK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REWIND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DONE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ERROR  = 2'd3;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NOSPACE = 3'd0;
   localparam logic [ERR_W-1:0] ERR_IO      = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NODEV   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_INTR    = 3'd3;
   localparam logic [ERR_W-1:0] ERR_BOUND   = 3'd4;

   // Search phases.
   localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DOUBLE    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_FIRST_REW = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PROBE     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PROBE_REW = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COUNT_W-1:0] seek_count;
      logic [SIZE_W-1:0]  medium_size_kib;
      logic [ERR_W-1:0]   error_code;
   } rsp_type;

endpackage

>>> sv/mssq_size.sv
// Scales a block count by the block size in KiB and saturates to the size field.
module mssq_size #(
   parameter int BW = mssq_pkg::MAX_BLOCKS_LOG2_DEF + 1
) (
   input  logic [BW-1:0]                  blocks,
   input  logic [mssq_pkg::KIB_W-1:0]     block_kib,
   output logic [mssq_pkg::SIZE_W-1:0]    size_kib
);

   localparam int PW = BW + mssq_pkg::KIB_W;
   localparam int EW = PW + mssq_pkg::SIZE_W;

   logic [PW-1:0] product;
   logic [EW-1:0] product_ext;

   assign product     = PW'(blocks) * PW'(block_kib);
   assign product_ext = {{mssq_pkg::SIZE_W{1'b0}}, product};

   always_comb begin
      if (product_ext[EW-1:mssq_pkg::SIZE_W] != '0) begin
         size_kib = '1;
      end else begin
         size_kib = product_ext[mssq_pkg::SIZE_W-1:0];
      end
   end

endmodule

>>> sv/mssq_step.sv
// Next-command logic: one input item against the current search state.
module mssq_step #(
   parameter int MAX_BLOCKS_LOG2 = mssq_pkg::MAX_BLOCKS_LOG2_DEF,
   parameter int BW = MAX_BLOCKS_LOG2 + 1
) (
   input  logic                           operation,
   input  logic [mssq_pkg::STATUS_W-1:0]  status,
   input  logic [mssq_pkg::KIB_W-1:0]     block_kib,
   input  logic [mssq_pkg::PHASE_W-1:0]   phase,
   input  logic [BW-1:0]                  low,
   input  logic [BW-1:0]                  high,
   output logic [mssq_pkg::PHASE_W-1:0]   phase_next,
   output logic [BW-1:0]                  low_next,
   output logic [BW-1:0]                  high_next,
   output logic                           emit,
   output mssq_pkg::rsp_type              rsp
);

   localparam int SW = mssq_pkg::COUNT_W;
   localparam logic [BW:0] LIMIT = {2'b01, {MAX_BLOCKS_LOG2{1'b0}}};

   logic [BW:0]      sum;
   logic [BW-1:0]    mid;
   logic [BW-1:0]    mid_p1;
   logic [BW-1:0]    dbl_src;
   logic [BW:0]      dbl;
   logic             dbl_over;
   logic [BW-1:0]    bs_low;
   logic [BW:0]      bs_sum;
   logic [BW-1:0]    bs_probe;
   logic             bs_finish;
   logic [mssq_pkg::SIZE_W-1:0] bs_size;
   logic [BW-1:0]    seek;
   logic [BW+SW-1:0] seek_ext;
   logic [mssq_pkg::ERR_W-1:0] other_err;

   assign sum    = {1'b0, low} + {1'b0, high};
   assign mid    = sum[BW:1];
   assign mid_p1 = mid + BW'(1);

   // A start restarts the doubling from a bound of one.
   assign dbl_src  = (operation == mssq_pkg::OP_START) ? BW'(1) : high;
   assign dbl      = {dbl_src, 1'b0};
   assign dbl_over = dbl > LIMIT;

   // A good probe raises the lower bound before the next binary step.
   assign bs_low    = (phase == mssq_pkg::PH_PROBE) ? mid_p1 : low;
   assign bs_sum    = {1'b0, bs_low} + {1'b0, high};
   assign bs_probe  = bs_sum[BW:1] + BW'(1);
   assign bs_finish = bs_low >= high;

   mssq_size #(.BW(BW)) u_size (
      .blocks   (bs_low),
      .block_kib(block_kib),
      .size_kib (bs_size)
   );

   always_comb begin
      case (status)
         mssq_pkg::ST_INTR:  other_err = mssq_pkg::ERR_INTR;
         mssq_pkg::ST_BUILD: other_err = mssq_pkg::ERR_NOSPACE;
         default:            other_err = mssq_pkg::ERR_IO;
      endcase
   end

   always_comb begin
      phase_next = phase;
      low_next   = low;
      high_next  = high;
      emit       = 1'b1;
      seek       = '0;
      rsp        = '0;

      if (operation == mssq_pkg::OP_START) begin
         low_next  = BW'(1);
         high_next = dbl[BW-1:0];
         phase_next = mssq_pkg::PH_DOUBLE;
         rsp.command = mssq_pkg::CMD_SEEK;
         seek = dbl[BW-1:0];
      end else begin
         unique case (phase) inside
            mssq_pkg::PH_DOUBLE: begin
               if (status == mssq_pkg::ST_DONE) begin
                  low_next  = high;
                  high_next = dbl[BW-1:0];
                  if (dbl_over) begin
                     phase_next = mssq_pkg::PH_IDLE;
                     rsp.command = mssq_pkg::CMD_ERROR;
                     rsp.error_code = mssq_pkg::ERR_BOUND;
                  end else begin
                     rsp.command = mssq_pkg::CMD_SEEK;
                     seek = dbl[BW-1:0];
                  end
               end else if (status == mssq_pkg::ST_FAILED) begin
                  phase_next = mssq_pkg::PH_FIRST_REW;
                  rsp.command = mssq_pkg::CMD_REWIND;
               end else begin
                  phase_next = mssq_pkg::PH_IDLE;
                  rsp.command = mssq_pkg::CMD_ERROR;
                  rsp.error_code = (status == mssq_pkg::ST_NOT_OPER) ?
                                   mssq_pkg::ERR_NODEV : other_err;
               end
            end
            mssq_pkg::PH_FIRST_REW,
            mssq_pkg::PH_PROBE,
            mssq_pkg::PH_PROBE_REW: begin
               if (status == mssq_pkg::ST_DONE) begin
                  low_next = bs_low;
                  if (bs_finish) begin
                     phase_next = mssq_pkg::PH_IDLE;
                     rsp.command = mssq_pkg::CMD_DONE;
                     rsp.medium_size_kib = bs_size;
                  end else begin
                     phase_next = mssq_pkg::PH_PROBE;
                     rsp.command = mssq_pkg::CMD_SEEK;
                     seek = bs_probe;
                  end
               end else if (status == mssq_pkg::ST_FAILED &&
                            phase == mssq_pkg::PH_PROBE) begin
                  high_next  = mid;
                  phase_next = mssq_pkg::PH_PROBE_REW;
                  rsp.command = mssq_pkg::CMD_REWIND;
               end else begin
                  phase_next = mssq_pkg::PH_IDLE;
                  rsp.command = mssq_pkg::CMD_ERROR;
                  if (status == mssq_pkg::ST_FAILED) begin
                     rsp.error_code = mssq_pkg::ERR_IO;
                  end else if (status == mssq_pkg::ST_NOT_OPER) begin
                     rsp.error_code = (phase == mssq_pkg::PH_PROBE_REW) ?
                                      mssq_pkg::ERR_IO : mssq_pkg::ERR_NODEV;
                  end else begin
                     rsp.error_code = other_err;
                  end
               end
            end
            default: begin
               // Completions arriving while idle are dropped.
               emit = 1'b0;
            end
         endcase
      end

      seek_ext = {{SW{1'b0}}, seek};
      rsp.seek_count = seek_ext[SW-1:0];
   end

endmodule

>>> sv/medium_size_search_sequencer_core.sv
// Top level of the medium size search sequencer: registers, handshakes and checks.
//
// The sequencer sizes a tape medium by trying seeks. Each transfer on the req_
// channel is a start event or the completion status of the command last
// issued; for each one the block answers with one transfer on the rsp_ channel
// holding the next command (seek, rewind, finished with a size in KiB, or an
// error). A completion that arrives while no search runs is dropped without a
// response. An item waits in the input register, where the next command and the
// new bounds are computed, until the output register is free, and then sits in
// the output register until it is taken, so a new item is accepted in every
// cycle while the response side keeps up. The critical path is the bound adder,
// the increment and the 7-bit size multiply with saturation that follow it.
// The block size register (reset value 2 KiB) may be written at any time
// through the csr_ channel but is only meaningful when written while no item is
// in flight.
module medium_size_search_sequencer_core #(
   parameter int MAX_BLOCKS_LOG2 = mssq_pkg::MAX_BLOCKS_LOG2_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [mssq_pkg::STATUS_W-1:0]  req_status,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mssq_pkg::CMD_W-1:0]     rsp_command,
   output logic [mssq_pkg::COUNT_W-1:0]   rsp_seek_count,
   output logic [mssq_pkg::SIZE_W-1:0]    rsp_medium_size_kib,
   output logic [mssq_pkg::ERR_W-1:0]     rsp_error_code,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mssq_pkg::KIB_W-1:0]     csr_block_kib
);

   // The bounds reach 2^MAX_BLOCKS_LOG2, which needs one bit more than the log.
   localparam int BW = MAX_BLOCKS_LOG2 + 1;

   // Configuration register. It is always ready to take a transfer.
   logic [mssq_pkg::KIB_W-1:0] kib_ff;

   // Input register.
   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic [mssq_pkg::STATUS_W-1:0] in_status_ff;

   // Search state.
   logic [mssq_pkg::PHASE_W-1:0]  phase_ff;
   logic [BW-1:0]                 low_ff;
   logic [BW-1:0]                 high_ff;

   // Output register.
   logic                          rsp_valid_ff;
   mssq_pkg::rsp_type             rsp_ff;

   // Step results.
   logic [mssq_pkg::PHASE_W-1:0]  phase_in;
   logic [BW-1:0]                 low_in;
   logic [BW-1:0]                 high_in;
   logic                          emit;
   mssq_pkg::rsp_type             rsp_in;

   logic out_free;
   logic advance;
   logic load_rsp;

   // The output register can take a new response when it is empty or its
   // current response is being transferred in this cycle. The held item is
   // processed only then, so the state never runs ahead of the responses.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign load_rsp  = advance && emit;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   mssq_step #(
      .MAX_BLOCKS_LOG2(MAX_BLOCKS_LOG2),
      .BW             (BW)
   ) u_step (
      .operation (in_op_ff),
      .status    (in_status_ff),
      .block_kib (kib_ff),
      .phase     (phase_ff),
      .low       (low_ff),
      .high      (high_ff),
      .phase_next(phase_in),
      .low_next  (low_in),
      .high_next (high_in),
      .emit      (emit),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kib_ff <= mssq_pkg::KIB_RESET;
      end else if (csr_valid && csr_ready) begin
         kib_ff <= csr_block_kib;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff     <= req_operation;
         in_status_ff <= req_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mssq_pkg::PH_IDLE;
         low_ff   <= BW'(1);
         high_ff  <= BW'(1);
      end else if (advance) begin
         phase_ff <= phase_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= load_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command         = rsp_ff.command;
   assign rsp_seek_count      = rsp_ff.seek_count;
   assign rsp_medium_size_kib = rsp_ff.medium_size_kib;
   assign rsp_error_code      = rsp_ff.error_code;

   // A response that is waiting is never overwritten by the next item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load_rsp)
      else $error("response overwritten while stalled");

   // While a search runs the lower bound never passes the upper bound.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mssq_pkg::PH_IDLE) |-> (low_ff <= high_ff))
      else $error("search bounds crossed");

   // A start always leads to a seek to two blocks in the doubling phase.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == mssq_pkg::OP_START) |=>
         (rsp_valid_ff && rsp_ff.command == mssq_pkg::CMD_SEEK &&
          rsp_ff.seek_count == mssq_pkg::COUNT_W'(2) &&
          phase_ff == mssq_pkg::PH_DOUBLE))
      else $error("start did not issue the first seek");

endmodule

>>> tb/sv/medium_size_search_sequencer_core_test.sv
// Self-checking testbench for the medium size search sequencer core.
`timescale 1ns / 1ps

module medium_size_search_sequencer_core_test;
   import mssq_pkg::*;

   // Completion status codes that the package does not name. All three end a search with
   // an I/O error.
   localparam logic [STATUS_W-1:0] ST_OTHER      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_START_FAIL = 3'd6;
   localparam logic [STATUS_W-1:0] ST_CODE7      = 3'd7;

   // The doubled upper bound may briefly reach twice the largest legal count, so the
   // bounds get one spare bit.
   localparam int BOUND_W = MAX_BLOCKS_LOG2_DEF + 2;
   localparam logic [BOUND_W-1:0] BOUND_LIMIT = BOUND_W'(1) << MAX_BLOCKS_LOG2_DEF;
   localparam logic [39:0] SIZE_CEILING = 40'h7FFF_FFFF;

   localparam int SEGMENTS          = 6;
   localparam int RESULTS_PER_SEG   = 117;
   localparam int SETTLE_CYCLES     = 6;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int MAX_REPORTED      = 10;

   // How a directed row is checked. A typed-in command is used where the answer is
   // obvious; the others go through the search predictor.
   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_NONE,
      CHECK_GIVEN
   } check_kind_type;

   typedef struct {
      logic                op;
      logic [STATUS_W-1:0] st;
      check_kind_type      kind;
      rsp_type             given;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_operation = 1'b0;
   logic [STATUS_W-1:0] req_status = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CMD_W-1:0]    rsp_command;
   logic [COUNT_W-1:0]  rsp_seek_count;
   logic [SIZE_W-1:0]   rsp_medium_size_kib;
   logic [ERR_W-1:0]    rsp_error_code;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [KIB_W-1:0]    csr_block_kib = '0;

   // Predictor state: the search phase, both bounds and the block size in KiB.
   logic [PHASE_W-1:0]  search_phase = PH_IDLE;
   logic [BOUND_W-1:0]  low_blocks = BOUND_W'(1);
   logic [BOUND_W-1:0]  high_blocks = BOUND_W'(1);
   logic [KIB_W-1:0]    size_unit_kib = KIB_RESET;

   // Commands that the block still owes, oldest first.
   rsp_type             pending_commands[$];
   stim_row_type        directed_rows[$];

   int                  fail_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 10;
   int                  recv_idle_pct = 65;

   // Stimulus shaping for the random part.
   int                  doubles_left = 0;
   int                  searches_started = 0;
   int                  segment = 0;
   bit                  deep_search = 1'b0;

   medium_size_search_sequencer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_status          (req_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_command         (rsp_command),
      .rsp_seek_count      (rsp_seek_count),
      .rsp_medium_size_kib (rsp_medium_size_kib),
      .rsp_error_code      (rsp_error_code),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_block_kib       (csr_block_kib)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // A hung handshake or a missing command ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("medium_size_search_sequencer_core_test: FAIL");
         $finish;
      end
   end

   function automatic rsp_type make_cmd(input logic [CMD_W-1:0] cmd,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [ERR_W-1:0] err);
      rsp_type r;
      r.command         = cmd;
      r.seek_count      = cnt;
      r.medium_size_kib = size;
      r.error_code      = err;
      return r;
   endfunction

   // Every error drops the search back to idle.
   function automatic rsp_type raise_error(input logic [ERR_W-1:0] err);
      search_phase = PH_IDLE;
      return make_cmd(CMD_ERROR, '0, '0, err);
   endfunction

   // Statuses that are neither done, failed nor not operational.
   function automatic rsp_type status_error(input logic [STATUS_W-1:0] st);
      if (st == ST_INTR) return raise_error(ERR_INTR);
      if (st == ST_BUILD) return raise_error(ERR_NOSPACE);
      return raise_error(ERR_IO);
   endfunction

   // Doubles the upper bound and seeks to it, unless it has grown past the largest count.
   function automatic rsp_type double_high();
      high_blocks = high_blocks << 1;
      if (high_blocks > BOUND_LIMIT) return raise_error(ERR_BOUND);
      search_phase = PH_DOUBLE;
      return make_cmd(CMD_SEEK, high_blocks[COUNT_W-1:0], '0, '0);
   endfunction

   // Either reports the size once the bounds meet or probes one past the midpoint.
   function automatic rsp_type binary_step();
      logic [39:0]        product;
      logic [BOUND_W-1:0] probe;
      if (low_blocks >= high_blocks) begin
         product = 40'(low_blocks) * 40'(size_unit_kib);
         if (product > SIZE_CEILING) product = SIZE_CEILING;
         search_phase = PH_IDLE;
         return make_cmd(CMD_DONE, '0, product[SIZE_W-1:0], '0);
      end
      probe = BOUND_W'((low_blocks + high_blocks) / 2 + 1);
      search_phase = PH_PROBE;
      return make_cmd(CMD_SEEK, probe[COUNT_W-1:0], '0, '0);
   endfunction

   // Steps the search by one accepted transfer. Returns whether a command follows.
   function automatic bit advance_search(input logic op, input logic [STATUS_W-1:0] st,
                                         output rsp_type r);
      r = '0;
      if (op == OP_START) begin
         low_blocks  = BOUND_W'(1);
         high_blocks = BOUND_W'(1);
         r = double_high();
         return 1'b1;
      end
      case (search_phase)
         PH_DOUBLE: begin
            if (st == ST_DONE) begin
               low_blocks = high_blocks;
               r = double_high();
            end else if (st == ST_FAILED) begin
               search_phase = PH_FIRST_REW;
               r = make_cmd(CMD_REWIND, '0, '0, '0);
            end else if (st == ST_NOT_OPER) begin
               r = raise_error(ERR_NODEV);
            end else begin
               r = status_error(st);
            end
         end
         PH_FIRST_REW: begin
            if (st == ST_DONE) r = binary_step();
            else if (st == ST_NOT_OPER) r = raise_error(ERR_NODEV);
            else if (st == ST_FAILED) r = raise_error(ERR_IO);
            else r = status_error(st);
         end
         PH_PROBE: begin
            if (st == ST_DONE) begin
               low_blocks = BOUND_W'((low_blocks + high_blocks) / 2 + 1);
               r = binary_step();
            end else if (st == ST_FAILED) begin
               high_blocks = BOUND_W'((low_blocks + high_blocks) / 2);
               search_phase = PH_PROBE_REW;
               r = make_cmd(CMD_REWIND, '0, '0, '0);
            end else if (st == ST_NOT_OPER) begin
               r = raise_error(ERR_NODEV);
            end else begin
               r = status_error(st);
            end
         end
         PH_PROBE_REW: begin
            if (st == ST_DONE) r = binary_step();
            else if (st == ST_FAILED || st == ST_NOT_OPER) r = raise_error(ERR_IO);
            else r = status_error(st);
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Chooses how many seeks of a new search succeed before one fails. The first search of
   // each segment goes all the way: either past the bound or to the largest medium, with
   // every probe succeeding. Most other searches stay short.
   function automatic int pick_depth();
      int roll;
      roll = $urandom_range(99);
      searches_started++;
      deep_search = 1'b0;
      if (searches_started == 1) begin
         deep_search = 1'b1;
         return (segment % 2 == 0) ? MAX_BLOCKS_LOG2_DEF : MAX_BLOCKS_LOG2_DEF - 1;
      end
      if (roll < 3) return MAX_BLOCKS_LOG2_DEF;
      if (roll < 6) return MAX_BLOCKS_LOG2_DEF - 1;
      if (roll < 12) return $urandom_range(MAX_BLOCKS_LOG2_DEF - 2, 6);
      return $urandom_range(5, 0);
   endfunction

   // Picks the next request from the predicted phase. Most requests follow a well-formed
   // search with random outcomes; a few are random statuses or restarts in mid-search.
   task automatic pick_request(output logic op, output logic [STATUS_W-1:0] st);
      int roll;
      roll = $urandom_range(99);
      op = OP_COMPLETE;
      st = STATUS_W'($urandom_range(7));
      if (search_phase == PH_IDLE) begin
         // The rest are stray completions, which the block drops without a command.
         if (roll < 85) begin
            op = OP_START;
            doubles_left = pick_depth();
         end
      end else if (!deep_search && roll < 4) begin
         op = OP_START;
         doubles_left = pick_depth();
      end else if (deep_search || roll >= 12) begin
         case (search_phase)
            PH_DOUBLE: begin
               if (doubles_left > 0) begin
                  st = ST_DONE;
                  doubles_left--;
               end else begin
                  st = ST_FAILED;
               end
            end
            PH_PROBE: st = (deep_search || $urandom_range(1)) ? ST_DONE : ST_FAILED;
            default: st = ST_DONE;
         endcase
      end
   endtask

   task automatic add_row(input logic op, input logic [STATUS_W-1:0] st,
                          input check_kind_type kind, input rsp_type given);
      stim_row_type row;
      row.op    = op;
      row.st    = st;
      row.kind  = kind;
      row.given = given;
      directed_rows.push_back(row);
   endtask

   // Drives one request, waits for its transfer and records what the block owes for it.
   task automatic issue_request(input logic op, input logic [STATUS_W-1:0] st,
                                input check_kind_type kind, input rsp_type given,
                                output bit produced);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_status    <= st;
      do @(posedge clock); while (!req_ready);
      produced = advance_search(op, st, predicted);
      case (kind)
         CHECK_PREDICTED: if (produced) pending_commands.push_back(predicted);
         CHECK_GIVEN:     pending_commands.push_back(given);
         default:         ;
      endcase
   endtask

   // Stops sending and lets every owed command drain. A dropped completion leaves nothing
   // to wait for, so a few extra cycles cover one that may still be in flight.
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_kib(input logic [KIB_W-1:0] kib);
      csr_valid     <= 1'b1;
      csr_block_kib <= kib;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      size_unit_kib = kib;
   endtask

   // Result side: a random ready, and every transfer is compared with the oldest owed
   // command.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_commands.size() == 0) begin
            if (fail_count < MAX_REPORTED)
               $display("unexpected command: cmd %0d count %0d size %0d err %0d",
                        rsp_command, rsp_seek_count, rsp_medium_size_kib, rsp_error_code);
            fail_count++;
         end else begin
            want = pending_commands.pop_front();
            if (rsp_command !== want.command || rsp_seek_count !== want.seek_count ||
                rsp_medium_size_kib !== want.medium_size_kib ||
                rsp_error_code !== want.error_code) begin
               if (fail_count < MAX_REPORTED)
                  $display("command mismatch: expected cmd %0d count %0d size %0d err %0d, %s",
                           want.command, want.seek_count, want.medium_size_kib,
                           want.error_code,
                           $sformatf("got cmd %0d count %0d size %0d err %0d",
                                     rsp_command, rsp_seek_count, rsp_medium_size_kib,
                                     rsp_error_code));
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      logic [KIB_W-1:0]    kib_plan[SEGMENTS];
      logic                op;
      logic [STATUS_W-1:0] st;
      bit                  produced;
      int                  results;

      // Directed rows run with the reset block size of 2 KiB. The first search walks
      // doubling, a failed seek, a probe that fails and one that succeeds, and the finish.
      add_row(OP_COMPLETE, ST_DONE,       CHECK_NONE,  '0);
      add_row(OP_START,    ST_CODE7,      CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_DONE,       CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(4), '0, '0));
      add_row(OP_COMPLETE, ST_DONE,       CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(8), '0, '0));
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_GIVEN, make_cmd(CMD_REWIND, '0, '0, '0));
      add_row(OP_COMPLETE, ST_DONE,       CHECK_PREDICTED, '0);
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_PREDICTED, '0);
      add_row(OP_COMPLETE, ST_DONE,       CHECK_PREDICTED, '0);
      add_row(OP_COMPLETE, ST_DONE,       CHECK_PREDICTED, '0);
      // Each error status during doubling, with a different ignored status on each start.
      add_row(OP_START,    ST_START_FAIL, CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_INTR,       CHECK_GIVEN, make_cmd(CMD_ERROR, '0, '0, ERR_INTR));
      add_row(OP_START,    ST_DONE,       CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_BUILD,      CHECK_GIVEN,
              make_cmd(CMD_ERROR, '0, '0, ERR_NOSPACE));
      add_row(OP_START,    ST_FAILED,     CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_OTHER,      CHECK_GIVEN, make_cmd(CMD_ERROR, '0, '0, ERR_IO));
      add_row(OP_START,    ST_INTR,       CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_NOT_OPER,   CHECK_GIVEN, make_cmd(CMD_ERROR, '0, '0, ERR_NODEV));
      // A device that is not operational during the first rewind reports no device.
      add_row(OP_START,    ST_BUILD,      CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_GIVEN, make_cmd(CMD_REWIND, '0, '0, '0));
      add_row(OP_COMPLETE, ST_NOT_OPER,   CHECK_GIVEN, make_cmd(CMD_ERROR, '0, '0, ERR_NODEV));
      // A failed first rewind is an I/O error.
      add_row(OP_START,    ST_NOT_OPER,   CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_GIVEN, make_cmd(CMD_REWIND, '0, '0, '0));
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_GIVEN, make_cmd(CMD_ERROR, '0, '0, ERR_IO));
      // During a rewind of the binary search, not operational is an I/O error as well.
      add_row(OP_START,    ST_OTHER,      CHECK_GIVEN, make_cmd(CMD_SEEK, COUNT_W'(2), '0, '0));
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_GIVEN, make_cmd(CMD_REWIND, '0, '0, '0));
      add_row(OP_COMPLETE, ST_DONE,       CHECK_PREDICTED, '0);
      add_row(OP_COMPLETE, ST_FAILED,     CHECK_PREDICTED, '0);
      add_row(OP_COMPLETE, ST_NOT_OPER,   CHECK_GIVEN, make_cmd(CMD_ERROR, '0, '0, ERR_IO));

      // Block sizes per random segment, with both extremes among them.
      kib_plan = '{7'd64, 7'd1, KIB_W'($urandom_range(64, 1)), 7'd64,
                   KIB_W'($urandom_range(64, 1)), 7'd1};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_request(directed_rows[i].op, directed_rows[i].st, directed_rows[i].kind,
                       directed_rows[i].given, produced);

      // Random segments: the block size is changed only once the block is idle. The first
      // two segments let the sender idle lightly and the receiver heavily, the next two
      // the other way round, and the last two run without gaps.
      for (segment = 0; segment < SEGMENTS; segment++) begin
         drain_commands();
         write_block_kib(kib_plan[segment]);
         case (segment / 2)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         searches_started = 0;
         results = 0;
         while (results < RESULTS_PER_SEG) begin
            pick_request(op, st);
            issue_request(op, st, CHECK_PREDICTED, '0, produced);
            if (produced) results++;
         end
      end

      drain_commands();
      if (fail_count == 0) begin
         $display("medium_size_search_sequencer_core_test: PASS");
      end else begin
         $display("medium_size_search_sequencer_core_test: FAIL");
      end
      $finish;
   end

endmodule
